// File: rtl/vn_pkg.sv
// vn_pkg: shared constants for the vector normalizer
// no dependencies
`default_nettype none

package vn_pkg;

    localparam int COMP_WIDTH_DEF = 32;
    localparam int UNIT_FRAC      = 30;
    localparam int OUT_WIDTH      = 32;
    localparam int QUOT_WIDTH     = UNIT_FRAC + 1;
    localparam int LANES          = 3;

endpackage

`default_nettype wire

// File: rtl/vec3_normalize.sv
// a beat passes front end, root chain, quotient init, divider chain, output register
// one beat per cycle unless stalled; the square root takes one stage per root bit
// and each divider one stage per quotient bit, all stages advance together
// in_stall is high only while the output register holds a beat that is stalled
// reset clears all valid bits asynchronously; payload registers are not reset
`default_nettype none

module vec3_normalize
    import vn_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [COMPONENT_WIDTH-1:0] vec_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] vec_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] vec_z,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [OUT_WIDTH-1:0]            unit_x,
    output logic signed [OUT_WIDTH-1:0]            unit_y,
    output logic signed [OUT_WIDTH-1:0]            unit_z,
    output logic [OUT_WIDTH-1:0]                   magnitude,
    output logic                                   degenerate
);

    localparam int W      = COMPONENT_WIDTH;
    localparam int SIDE_W = LANES * W + LANES + 1;
    localparam int DSTEPS = UNIT_FRAC;

    logic en;

    // front end
    logic                    fe_v;
    logic [2*W-1:0]          fe_sum;
    logic [LANES-1:0][W-1:0] fe_abs;
    logic [LANES-1:0]        fe_neg;
    logic                    fe_deg;

    // square root chain
    logic              sq_v    [0:W];
    logic [2*W-1:0]    sq_sum  [0:W];
    logic [W+1:0]      sq_rem  [0:W];
    logic [W-1:0]      sq_root [0:W];
    logic [SIDE_W-1:0] sq_side [0:W];

    // divider chain
    logic                           dv_v    [0:DSTEPS];
    logic [W-1:0]                   dv_div  [0:DSTEPS];
    logic [LANES-1:0][W-1:0]        dv_rem  [0:DSTEPS];
    logic [LANES-1:0][QUOT_WIDTH-1:0] dv_quot [0:DSTEPS];
    logic [LANES-1:0]               dv_neg  [0:DSTEPS];
    logic                           dv_deg  [0:DSTEPS];

    logic [LANES-1:0][W-1:0] init_abs;
    logic [LANES-1:0][W-1:0] init_rem_next;
    logic [LANES-1:0]        init_ge;
    logic [LANES-1:0][W-1:0] init_rem_reg;
    logic [LANES-1:0]        init_q_reg;
    logic [W-1:0]            init_div_reg;
    logic [LANES-1:0]        init_neg_reg;
    logic                    init_deg_reg;
    logic                    init_v_reg;

    logic                              out_v_reg;
    logic [LANES-1:0][OUT_WIDTH-1:0]   unit_reg;
    logic [LANES-1:0][OUT_WIDTH-1:0]   unit_next;
    logic [OUT_WIDTH-1:0]              mag_reg;
    logic [OUT_WIDTH-1:0]              mag_next;
    logic                              deg_reg;

    assign en       = !out_v_reg || !out_stall;
    assign in_stall = !en;

    vn_square #(.COMPONENT_WIDTH(W)) u_square (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .v_in    (in_valid),
        .comp_in ({vec_z, vec_y, vec_x}),
        .v_out   (fe_v),
        .sum_out (fe_sum),
        .abs_out (fe_abs),
        .neg_out (fe_neg),
        .deg_out (fe_deg)
    );

    assign sq_v[0]    = fe_v;
    assign sq_sum[0]  = fe_sum;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = {fe_deg, fe_neg, fe_abs};

    for (genvar i = 0; i < W; i++)
    begin : g_sqrt
        vn_sqrt_step #(.COMPONENT_WIDTH(W), .SIDE_WIDTH(SIDE_W)) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (sq_v[i]),
            .sum_in   (sq_sum[i]),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .side_in  (sq_side[i]),
            .v_out    (sq_v[i+1]),
            .sum_out  (sq_sum[i+1]),
            .rem_out  (sq_rem[i+1]),
            .root_out (sq_root[i+1]),
            .side_out (sq_side[i+1])
        );
    end

    // integer quotient bit, the component never exceeds the length
    assign init_abs = sq_side[W][LANES*W-1:0];

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            init_ge[k]       = (init_abs[k] >= sq_root[W]);
            init_rem_next[k] = init_ge[k] ? (init_abs[k] - sq_root[W]) : init_abs[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_v_reg <= 1'b0;
        end
        else if (en)
        begin
            init_v_reg <= sq_v[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            init_rem_reg <= init_rem_next;
            init_q_reg   <= init_ge;
            init_div_reg <= sq_root[W];
            init_neg_reg <= sq_side[W][LANES*W +: LANES];
            init_deg_reg <= sq_side[W][SIDE_W-1];
        end
    end

    assign dv_v[0]   = init_v_reg;
    assign dv_div[0] = init_div_reg;
    assign dv_rem[0] = init_rem_reg;
    assign dv_neg[0] = init_neg_reg;
    assign dv_deg[0] = init_deg_reg;

    for (genvar k = 0; k < LANES; k++)
    begin : g_quot_init
        assign dv_quot[0][k] = {{(QUOT_WIDTH-1){1'b0}}, init_q_reg[k]};
    end

    for (genvar j = 0; j < DSTEPS; j++)
    begin : g_div
        vn_div_step #(.COMPONENT_WIDTH(W)) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (dv_v[j]),
            .div_in   (dv_div[j]),
            .rem_in   (dv_rem[j]),
            .quot_in  (dv_quot[j]),
            .neg_in   (dv_neg[j]),
            .deg_in   (dv_deg[j]),
            .v_out    (dv_v[j+1]),
            .div_out  (dv_div[j+1]),
            .rem_out  (dv_rem[j+1]),
            .quot_out (dv_quot[j+1]),
            .neg_out  (dv_neg[j+1]),
            .deg_out  (dv_deg[j+1])
        );
    end

    // magnitude saturates when the length is wider than the port
    if (W > OUT_WIDTH)
    begin : g_mag_sat
        always_comb
        begin
            if (dv_div[DSTEPS][W-1:OUT_WIDTH] != '0)
            begin
                mag_next = '1;
            end
            else
            begin
                mag_next = dv_div[DSTEPS][OUT_WIDTH-1:0];
            end
        end
    end
    else
    begin : g_mag_ext
        assign mag_next = OUT_WIDTH'(dv_div[DSTEPS]);
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (dv_deg[DSTEPS])
            begin
                unit_next[k] = (k == 0) ? (OUT_WIDTH'(1) << UNIT_FRAC) : '0;
            end
            else if (dv_neg[DSTEPS][k])
            begin
                unit_next[k] = '0 - OUT_WIDTH'(dv_quot[DSTEPS][k]);
            end
            else
            begin
                unit_next[k] = OUT_WIDTH'(dv_quot[DSTEPS][k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= dv_v[DSTEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_reg <= unit_next;
            mag_reg  <= dv_deg[DSTEPS] ? '0 : mag_next;
            deg_reg  <= dv_deg[DSTEPS];
        end
    end

    assign out_valid  = out_v_reg;
    assign unit_x     = unit_reg[0];
    assign unit_y     = unit_reg[1];
    assign unit_z     = unit_reg[2];
    assign magnitude  = mag_reg;
    assign degenerate = deg_reg;

endmodule

`default_nettype wire

// File: rtl/vn_square.sv
// vn_square: front end, absolute values, squares and the squared length
// depends on vn_pkg
`default_nettype none

module vn_square
    import vn_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                v_in,
    input  wire logic [LANES-1:0][COMPONENT_WIDTH-1:0] comp_in,
    output logic                                     v_out,
    output logic [2*COMPONENT_WIDTH-1:0]             sum_out,
    output logic [LANES-1:0][COMPONENT_WIDTH-1:0]    abs_out,
    output logic [LANES-1:0]                         neg_out,
    output logic                                     deg_out
);

    localparam int W = COMPONENT_WIDTH;

    logic                      v1_reg, v2_reg, v3_reg;
    logic [LANES-1:0][W-1:0]   abs1_reg, abs2_reg, abs3_reg;
    logic [LANES-1:0]          neg1_reg, neg2_reg, neg3_reg;
    logic [LANES-1:0][2*W-1:0] sq2_reg;
    logic [2*W-1:0]            sum3_reg;
    logic [LANES-1:0][W-1:0]   abs1_next;
    logic [LANES-1:0]          neg1_next;
    logic [2*W-1:0]            sum3_next;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            neg1_next[k] = comp_in[k][W-1];
            abs1_next[k] = comp_in[k][W-1] ? (~comp_in[k] + W'(1)) : comp_in[k];
        end
        sum3_next = sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abs1_reg <= abs1_next;
            neg1_reg <= neg1_next;
            for (int k = 0; k < LANES; k++)
            begin
                sq2_reg[k] <= abs1_reg[k] * abs1_reg[k];
            end
            abs2_reg <= abs1_reg;
            neg2_reg <= neg1_reg;
            sum3_reg <= sum3_next;
            abs3_reg <= abs2_reg;
            neg3_reg <= neg2_reg;
        end
    end

    assign v_out   = v3_reg;
    assign sum_out = sum3_reg;
    assign abs_out = abs3_reg;
    assign neg_out = neg3_reg;
    assign deg_out = (sum3_reg == '0);

endmodule

`default_nettype wire

// File: rtl/vn_sqrt_step.sv
// vn_sqrt_step: one root bit of the restoring square root, registered
// depends on vn_pkg
`default_nettype none

module vn_sqrt_step
    import vn_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF,
    parameter int SIDE_WIDTH      = 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         v_in,
    input  wire logic [2*COMPONENT_WIDTH-1:0] sum_in,
    input  wire logic [COMPONENT_WIDTH+1:0]   rem_in,
    input  wire logic [COMPONENT_WIDTH-1:0]   root_in,
    input  wire logic [SIDE_WIDTH-1:0]        side_in,
    output logic                              v_out,
    output logic [2*COMPONENT_WIDTH-1:0]      sum_out,
    output logic [COMPONENT_WIDTH+1:0]        rem_out,
    output logic [COMPONENT_WIDTH-1:0]        root_out,
    output logic [SIDE_WIDTH-1:0]             side_out
);

    localparam int W = COMPONENT_WIDTH;

    logic           v_reg;
    logic [2*W-1:0] sum_reg;
    logic [W+1:0]   rem_reg;
    logic [W-1:0]   root_reg;
    logic [SIDE_WIDTH-1:0] side_reg;
    logic [W+3:0]   cand;
    logic [W+3:0]   trial;
    logic           ge;
    logic [W+3:0]   diff;

    always_comb
    begin
        cand  = {rem_in, sum_in[2*W-1:2*W-2]};
        trial = {2'b00, root_in, 2'b01};
        ge    = (cand >= trial);
        diff  = ge ? (cand - trial) : cand;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= {sum_in[2*W-3:0], 2'b00};
            rem_reg  <= diff[W+1:0];
            root_reg <= {root_in[W-2:0], ge};
            side_reg <= side_in;
        end
    end

    assign v_out    = v_reg;
    assign sum_out  = sum_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

// File: rtl/vn_div_step.sv
// vn_div_step: one quotient bit of three restoring dividers, registered
// depends on vn_pkg
`default_nettype none

module vn_div_step
    import vn_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic                                  v_in,
    input  wire logic [COMPONENT_WIDTH-1:0]            div_in,
    input  wire logic [LANES-1:0][COMPONENT_WIDTH-1:0] rem_in,
    input  wire logic [LANES-1:0][QUOT_WIDTH-1:0]      quot_in,
    input  wire logic [LANES-1:0]                      neg_in,
    input  wire logic                                  deg_in,
    output logic                                       v_out,
    output logic [COMPONENT_WIDTH-1:0]                 div_out,
    output logic [LANES-1:0][COMPONENT_WIDTH-1:0]      rem_out,
    output logic [LANES-1:0][QUOT_WIDTH-1:0]           quot_out,
    output logic [LANES-1:0]                           neg_out,
    output logic                                       deg_out
);

    localparam int W = COMPONENT_WIDTH;

    logic                           v_reg;
    logic [W-1:0]                   div_reg;
    logic [LANES-1:0][W-1:0]        rem_reg;
    logic [LANES-1:0][QUOT_WIDTH-1:0] quot_reg;
    logic [LANES-1:0]               neg_reg;
    logic                           deg_reg;
    logic [LANES-1:0][W:0]          shifted;
    logic [LANES-1:0]               ge;
    logic [LANES-1:0][W:0]          diff;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            shifted[k] = {rem_in[k], 1'b0};
            ge[k]      = (shifted[k] >= {1'b0, div_in});
            diff[k]    = ge[k] ? (shifted[k] - {1'b0, div_in}) : shifted[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                rem_reg[k]  <= diff[k][W-1:0];
                quot_reg[k] <= {quot_in[k][QUOT_WIDTH-2:0], ge[k]};
            end
            div_reg <= div_in;
            neg_reg <= neg_in;
            deg_reg <= deg_in;
        end
    end

    assign v_out    = v_reg;
    assign div_out  = div_reg;
    assign rem_out  = rem_reg;
    assign quot_out = quot_reg;
    assign neg_out  = neg_reg;
    assign deg_out  = deg_reg;

endmodule

`default_nettype wire

// File: rtl/vn_checker.sv
// vn_checker: port-level assertions for vec3_normalize, bound to the top level
// depends on vn_pkg
`default_nettype none

module vn_checker
    import vn_pkg::*;
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic signed [OUT_WIDTH-1:0] unit_x,
    input wire logic signed [OUT_WIDTH-1:0] unit_y,
    input wire logic signed [OUT_WIDTH-1:0] unit_z,
    input wire logic [OUT_WIDTH-1:0]        magnitude,
    input wire logic                        degenerate
);

    localparam logic signed [OUT_WIDTH-1:0] ONE = OUT_WIDTH'(1) << UNIT_FRAC;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(unit_x) && $stable(magnitude))
        else $error("stalled output beat changed");

    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled output beat");

    a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> unit_x == ONE && unit_y == 0 && unit_z == 0
            && magnitude == 0)
        else $error("degenerate beat is not the unit x vector");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> unit_x <= ONE && unit_x >= -ONE && unit_y <= ONE
            && unit_y >= -ONE && unit_z <= ONE && unit_z >= -ONE)
        else $error("unit component out of range");

    a_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |-> magnitude != 0)
        else $error("nonzero vector with zero length");

endmodule

bind vec3_normalize vn_checker u_vn_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .unit_x     (unit_x),
    .unit_y     (unit_y),
    .unit_z     (unit_z),
    .magnitude  (magnitude),
    .degenerate (degenerate)
);

`default_nettype wire
